// ===== sv/efsm_pkg.sv =====
// Shared types, constants and the microcode store of the editable state machine.
package efsm_pkg;

  // Table size and index width.
  localparam int STATE_COUNT = 8;
  localparam int IDX_W       = $clog2(STATE_COUNT);
  localparam int UPC_W       = 4;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [STATE_COUNT-1:0] smask_t;
  typedef logic [UPC_W-1:0]       upc_t;

  // Command codes.
  localparam logic [2:0] OP_STEP      = 3'd0;
  localparam logic [2:0] OP_CHANGE    = 3'd1;
  localparam logic [2:0] OP_GARBAGE   = 3'd2;
  localparam logic [2:0] OP_DEL_STATE = 3'd3;
  localparam logic [2:0] OP_DEL_GARB  = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_DELETED = 2'd1;
  localparam logic [1:0] ST_ALREADY = 2'd2;

  // Reset contents of the successor tables, states A to H.
  localparam idx_t SUCC0_RST [STATE_COUNT] =
    '{3'd0, 3'd4, 3'd5, 3'd1, 3'd6, 3'd3, 3'd7, 3'd0};
  localparam idx_t SUCC1_RST [STATE_COUNT] =
    '{3'd2, 3'd0, 3'd3, 3'd4, 3'd5, 3'd7, 3'd1, 3'd6};
  localparam idx_t RESET_STATE = 3'd1;

  // Datapath actions selected by a control word.
  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_STEP,
    ACT_CHANGE,
    ACT_MARK_INIT,
    ACT_MARK_PASS,
    ACT_DEL_STATE,
    ACT_GARB_REPORT,
    ACT_GARB_DELETE
  } action_t;

  // Sequencing of the step counter.
  typedef enum logic [1:0] {
    JC_NEXT,
    JC_WHILE_CHANGED,
    JC_END
  } jcond_t;

  typedef struct packed {
    action_t act;
    jcond_t  jc;
    upc_t    target;
  } uword_t;

  // Microcode entry points.
  localparam upc_t UA_STEP      = 4'd0;
  localparam upc_t UA_CHANGE    = 4'd1;
  localparam upc_t UA_GARBAGE   = 4'd2;
  localparam upc_t UA_GARB_LOOP = 4'd3;
  localparam upc_t UA_GARB_OUT  = 4'd4;
  localparam upc_t UA_DELG      = 4'd5;
  localparam upc_t UA_DELG_LOOP = 4'd6;
  localparam upc_t UA_DELG_OUT  = 4'd7;
  localparam upc_t UA_DEL_STATE = 4'd8;
  localparam upc_t UA_IDLE_OP   = 4'd9;

  // Control store: one word per program step.
  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    w = '{act: ACT_NOP, jc: JC_END, target: UA_IDLE_OP};
    case (a)
      UA_STEP:      w = '{act: ACT_STEP,        jc: JC_END,  target: UA_STEP};
      UA_CHANGE:    w = '{act: ACT_CHANGE,      jc: JC_END,  target: UA_CHANGE};
      UA_GARBAGE:   w = '{act: ACT_MARK_INIT,   jc: JC_NEXT, target: UA_GARBAGE};
      UA_GARB_LOOP: w = '{act: ACT_MARK_PASS,   jc: JC_WHILE_CHANGED,
                          target: UA_GARB_LOOP};
      UA_GARB_OUT:  w = '{act: ACT_GARB_REPORT, jc: JC_END,  target: UA_GARB_OUT};
      UA_DELG:      w = '{act: ACT_MARK_INIT,   jc: JC_NEXT, target: UA_DELG};
      UA_DELG_LOOP: w = '{act: ACT_MARK_PASS,   jc: JC_WHILE_CHANGED,
                          target: UA_DELG_LOOP};
      UA_DELG_OUT:  w = '{act: ACT_GARB_DELETE, jc: JC_END,  target: UA_DELG_OUT};
      UA_DEL_STATE: w = '{act: ACT_DEL_STATE,   jc: JC_END,  target: UA_DEL_STATE};
      default:      w = '{act: ACT_NOP,         jc: JC_END,  target: UA_IDLE_OP};
    endcase
    return w;
  endfunction

  // Dispatch from command code to the first program step.
  function automatic upc_t entry(input logic [2:0] op);
    upc_t a;
    case (op)
      OP_STEP:      a = UA_STEP;
      OP_CHANGE:    a = UA_CHANGE;
      OP_GARBAGE:   a = UA_GARBAGE;
      OP_DEL_STATE: a = UA_DEL_STATE;
      OP_DEL_GARB:  a = UA_DELG;
      default:      a = UA_IDLE_OP;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/editable_fsm_with_reachability_sweep.sv =====
// Top level: editable eight-state machine driven by a microcoded sequencer.
// Step, change, delete state and unused codes: the entry step ends the program.
// Identify and delete garbage: one marking pass per cycle until the reachable set
// stops growing (at most eight passes), then a final step reports or deletes it.
// One command at a time; busy falls in the cycle the result strobe is shown.
// Synchronous active-low reset restores the table and the current state (B).
// The result is shown for one cycle only; the receiver cannot stall it.
module editable_fsm_with_reachability_sweep (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_op,
  input  logic       in_branch_bit,
  input  logic [2:0] in_target_state,
  output logic       out_valid,
  output logic [2:0] out_current_state,
  output logic [7:0] out_garbage_mask,
  output logic [1:0] out_status
);

  // Machine table and current state.
  efsm_pkg::idx_t   cur_r, cur_nxt;
  efsm_pkg::idx_t   succ0_r [efsm_pkg::STATE_COUNT];
  efsm_pkg::idx_t   succ0_nxt [efsm_pkg::STATE_COUNT];
  efsm_pkg::idx_t   succ1_r [efsm_pkg::STATE_COUNT];
  efsm_pkg::idx_t   succ1_nxt [efsm_pkg::STATE_COUNT];
  efsm_pkg::smask_t del_r, del_nxt;
  efsm_pkg::smask_t reach_r, reach_nxt;

  // Sequencer and latched command.
  logic             busy_r;
  efsm_pkg::upc_t   upc_r;
  logic [2:0]       op_r;
  logic             bit_r;
  efsm_pkg::idx_t   tgt_r;

  // Result registers.
  logic             out_valid_r;
  efsm_pkg::idx_t   out_cur_r;
  efsm_pkg::smask_t out_mask_r;
  logic [1:0]       out_status_r;

  efsm_pkg::uword_t uw;
  efsm_pkg::smask_t pass_next;
  efsm_pkg::smask_t garb;
  efsm_pkg::smask_t res_mask;
  logic [1:0]       res_status;
  logic             accept;
  logic             pass_changed;

  assign accept = start && !busy_r;
  assign uw     = efsm_pkg::ucode(upc_r);

  // One marking pass: every reachable live state passes reach on to its successors.
  always_comb begin
    pass_next = reach_r;
    for (int i = 0; i < efsm_pkg::STATE_COUNT; i++) begin
      if (reach_r[i] && !del_r[i]) begin
        pass_next[succ0_r[i]] = 1'b1;
        pass_next[succ1_r[i]] = 1'b1;
      end
    end
  end

  assign pass_changed = (pass_next != reach_r);
  assign garb         = ~reach_r & ~del_r;

  // Datapath driven by the current control word.
  always_comb begin
    cur_nxt    = cur_r;
    succ0_nxt  = succ0_r;
    succ1_nxt  = succ1_r;
    del_nxt    = del_r;
    reach_nxt  = reach_r;
    res_mask   = '0;
    res_status = efsm_pkg::ST_NONE;
    if (busy_r) begin
      case (uw.act)
        efsm_pkg::ACT_STEP: begin
          cur_nxt = bit_r ? succ1_r[cur_r] : succ0_r[cur_r];
        end
        efsm_pkg::ACT_CHANGE: begin
          if (!del_r[tgt_r]) begin
            if (bit_r) succ1_nxt[cur_r] = tgt_r;
            else       succ0_nxt[cur_r] = tgt_r;
          end
        end
        efsm_pkg::ACT_MARK_INIT: begin
          reach_nxt        = '0;
          reach_nxt[cur_r] = 1'b1;
        end
        efsm_pkg::ACT_MARK_PASS: begin
          reach_nxt = pass_next;
        end
        efsm_pkg::ACT_DEL_STATE: begin
          res_status     = del_r[tgt_r] ? efsm_pkg::ST_ALREADY : efsm_pkg::ST_DELETED;
          del_nxt[tgt_r] = 1'b1;
        end
        efsm_pkg::ACT_GARB_REPORT: begin
          res_mask = garb;
        end
        efsm_pkg::ACT_GARB_DELETE: begin
          res_mask = garb;
          del_nxt  = del_r | garb;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer, table state and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      upc_r        <= efsm_pkg::UA_IDLE_OP;
      out_valid_r  <= 1'b0;
      cur_r        <= efsm_pkg::RESET_STATE;
      succ0_r      <= efsm_pkg::SUCC0_RST;
      succ1_r      <= efsm_pkg::SUCC1_RST;
      del_r        <= '0;
    end else begin
      out_valid_r <= 1'b0;
      cur_r       <= cur_nxt;
      succ0_r     <= succ0_nxt;
      succ1_r     <= succ1_nxt;
      del_r       <= del_nxt;
      reach_r     <= reach_nxt;
      if (accept) begin
        busy_r <= 1'b1;
        upc_r  <= efsm_pkg::entry(in_op);
        op_r   <= in_op;
        bit_r  <= in_branch_bit;
        tgt_r  <= in_target_state;
      end else if (busy_r) begin
        case (uw.jc)
          efsm_pkg::JC_NEXT: begin
            upc_r <= upc_r + efsm_pkg::upc_t'(1);
          end
          efsm_pkg::JC_WHILE_CHANGED: begin
            upc_r <= pass_changed ? uw.target : upc_r + efsm_pkg::upc_t'(1);
          end
          default: begin
            busy_r       <= 1'b0;
            out_valid_r  <= 1'b1;
            out_cur_r    <= cur_nxt;
            out_mask_r   <= res_mask;
            out_status_r <= res_status;
          end
        endcase
      end
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_current_state = out_cur_r;
  assign out_garbage_mask  = out_mask_r;
  assign out_status        = out_status_r;

  // A transaction accepted always leaves the sequencer busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("sequencer did not start on an accepted transaction");

  // The result strobe coincides with the sequencer going idle.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy_r)
    else $error("result shown while the sequencer is still busy");

  // Only a delete-state command reports a status.
  a_status_op: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != efsm_pkg::ST_NONE) |-> op_r == efsm_pkg::OP_DEL_STATE)
    else $error("status reported for a command other than delete state");

  // Garbage reported by identify is live; garbage reported by delete is now deleted.
  a_garb_live: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && op_r == efsm_pkg::OP_GARBAGE) |-> (out_mask_r & del_r) == '0)
    else $error("reported garbage includes a deleted state");

  a_garb_deleted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && op_r == efsm_pkg::OP_DEL_GARB) |-> (out_mask_r & ~del_r) == '0)
    else $error("garbage reported as deleted is still live");

  // Deleted marks are never cleared outside reset.
  a_del_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (($past(del_r) & ~del_r) == '0))
    else $error("a deleted mark was cleared");

endmodule
